[rtl/iefp_pkg.sv]
package iefp_pkg;

    // Frame format
    localparam int MAX_FRAME    = 64;
    localparam int COUNT_W      = $clog2(MAX_FRAME + 1);
    localparam int MIN_END_LEN  = 7;
    localparam int MIN_DATA_LEN = 23;
    localparam int ANGLE_POS    = 17;
    localparam int ANGLE_BYTES  = 6;

    localparam logic [7:0] START_BYTE = 8'h3A;
    localparam logic [7:0] END_FIRST  = 8'h0D;
    localparam logic [7:0] END_SECOND = 8'h0A;

    // Angle constants, centidegrees
    localparam logic [15:0]        FULL_TURN_U = 16'd36000;
    localparam logic signed [16:0] FULL_TURN_S = 17'sd36000;
    localparam logic signed [16:0] HALF_TURN_S = 17'sd18000;

    // Queue between parser and yaw tracker
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register indexes
    localparam logic CFG_DEVICE_ID = 1'b0;
    localparam logic CFG_YAW_LIMIT = 1'b1;

    localparam logic [7:0]  DEVICE_ID_RST = 8'd1;
    localparam logic [15:0] YAW_LIMIT_RST = 16'd36000;

    // Input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_ZERO = 1'b1;

    typedef enum logic {
        K_ZERO  = 1'b0,
        K_FRAME = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
    } t_q_entry;

    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_port;

endpackage

[rtl/iefp_front.sv]
module iefp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_op,
    input  logic [7:0]            i_byte,
    input  logic [7:0]            i_device_id,
    output iefp_pkg::t_q_port     o_push
);

    logic                         r_in_frame, n_in_frame;
    logic [iefp_pkg::COUNT_W-1:0] r_count, n_count;
    logic [7:0]                   r_prev, n_prev;
    logic [7:0]                   r_angle [iefp_pkg::ANGLE_BYTES];

    logic [iefp_pkg::COUNT_W-1:0] w_next_count;
    logic [iefp_pkg::COUNT_W-1:0] w_angle_off;
    logic                         w_store;
    logic                         w_capture;
    logic [7:0]                   w_yaw_hi;
    logic [15:0]                  w_yaw_raw;

    assign w_next_count = r_count + iefp_pkg::COUNT_W'(1);
    assign w_angle_off  = r_count - iefp_pkg::COUNT_W'(iefp_pkg::ANGLE_POS);
    assign w_store      = i_accept && (i_op == iefp_pkg::OP_BYTE) && r_in_frame
                          && (r_count != iefp_pkg::COUNT_W'(iefp_pkg::MAX_FRAME));
    assign w_capture    = w_store && (r_count >= iefp_pkg::COUNT_W'(iefp_pkg::ANGLE_POS))
                          && (w_angle_off < iefp_pkg::COUNT_W'(iefp_pkg::ANGLE_BYTES));

    // Yaw high byte may be the terminating byte itself on a minimal frame
    assign w_yaw_hi  = (r_count == iefp_pkg::COUNT_W'(iefp_pkg::ANGLE_POS + 5)) ?
                       i_byte : r_angle[5];
    assign w_yaw_raw = {w_yaw_hi, r_angle[4]};

    // Frame tracking
    always_comb begin
        n_in_frame   = r_in_frame;
        n_count      = r_count;
        n_prev       = r_prev;
        o_push.valid = 1'b0;
        o_push.entry.kind  = iefp_pkg::K_FRAME;
        o_push.entry.roll  = {r_angle[1], r_angle[0]};
        o_push.entry.pitch = {r_angle[3], r_angle[2]};
        o_push.entry.yaw   = w_yaw_raw[15] ? (w_yaw_raw + iefp_pkg::FULL_TURN_U) : w_yaw_raw;
        if (i_accept) begin
            if (i_op == iefp_pkg::OP_ZERO) begin
                o_push.valid      = 1'b1;
                o_push.entry.kind = iefp_pkg::K_ZERO;
            end else if (!r_in_frame) begin
                if (i_byte == iefp_pkg::START_BYTE) begin
                    n_in_frame = 1'b1;
                    n_count    = iefp_pkg::COUNT_W'(1);
                    n_prev     = i_byte;
                end
            end else if (!w_store) begin
                // overflow: drop the frame, the byte is not kept
                n_in_frame = 1'b0;
                n_count    = '0;
            end else if ((w_next_count == iefp_pkg::COUNT_W'(2))
                         && (i_byte != i_device_id)) begin
                n_in_frame = 1'b0;
                n_count    = '0;
            end else if ((w_next_count >= iefp_pkg::COUNT_W'(iefp_pkg::MIN_END_LEN))
                         && (r_prev == iefp_pkg::END_FIRST)
                         && (i_byte == iefp_pkg::END_SECOND)) begin
                n_in_frame   = 1'b0;
                n_count      = '0;
                o_push.valid = (w_next_count >= iefp_pkg::COUNT_W'(iefp_pkg::MIN_DATA_LEN));
            end else begin
                n_count = w_next_count;
                n_prev  = i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
        end
    end

    // Capture the angle bytes and the last stored byte
    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        if (w_capture) begin
            r_angle[w_angle_off[$clog2(iefp_pkg::ANGLE_BYTES)-1:0]] <= i_byte;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_tracks_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame == (r_count != '0))
        else $error("byte count out of step with frame flag");
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= iefp_pkg::COUNT_W'(iefp_pkg::MAX_FRAME))
        else $error("byte count beyond frame limit");
`endif

endmodule

[rtl/iefp_queue.sv]
module iefp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iefp_pkg::t_q_port  i_push,
    input  logic               i_pop,
    output logic               o_full,
    output iefp_pkg::t_q_port  o_head
);

    iefp_pkg::t_q_entry             r_mem [iefp_pkg::Q_DEPTH];
    logic [iefp_pkg::Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [iefp_pkg::Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [iefp_pkg::Q_CNT_W-1:0]   r_count, n_count;
    logic                           w_do_pop;

    assign o_full       = (r_count == iefp_pkg::Q_CNT_W'(iefp_pkg::Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];
    assign w_do_pop     = i_pop && o_head.valid;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == iefp_pkg::Q_PTR_W'(iefp_pkg::Q_DEPTH - 1)) ?
                       '0 : r_wr_ptr + iefp_pkg::Q_PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == iefp_pkg::Q_PTR_W'(iefp_pkg::Q_DEPTH - 1)) ?
                       '0 : r_rd_ptr + iefp_pkg::Q_PTR_W'(1);
        end
        if (i_push.valid && !w_do_pop) begin
            n_count = r_count + iefp_pkg::Q_CNT_W'(1);
        end else if (!i_push.valid && w_do_pop) begin
            n_count = r_count - iefp_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.valid && o_full))
        else $error("push into full queue");
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= iefp_pkg::Q_CNT_W'(iefp_pkg::Q_DEPTH))
        else $error("queue occupancy beyond depth");
`endif

endmodule

[rtl/iefp_back.sv]
module iefp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iefp_pkg::t_q_port  i_head,
    output logic               o_pop,
    input  logic [15:0]        i_yaw_limit,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_roll,
    output logic [15:0]        o_pitch,
    output logic [15:0]        o_yaw,
    output logic [16:0]        o_running
);

    logic                      r_out_valid, n_out_valid;
    logic                      r_base_valid, n_base_valid;
    logic [15:0]               r_prev_yaw, n_prev_yaw;
    logic signed [16:0]        r_running, n_running;
    logic [15:0]               r_roll, r_pitch, r_yaw;
    logic [16:0]               r_run_out;

    logic signed [16:0]        w_delta_raw;
    logic signed [16:0]        w_delta;
    logic signed [17:0]        w_sum;
    logic signed [17:0]        w_lim;
    logic                      w_is_zero;
    logic                      w_take_frame;

    assign w_is_zero    = (i_head.entry.kind == iefp_pkg::K_ZERO);
    assign o_pop        = i_head.valid && (w_is_zero || !r_out_valid || i_ready);
    assign w_take_frame = o_pop && !w_is_zero;

    // Wrap the yaw step into a half turn either way, then accumulate and clamp
    assign w_delta_raw = $signed({1'b0, i_head.entry.yaw}) - $signed({1'b0, r_prev_yaw});
    assign w_sum       = 18'(r_running) + 18'(w_delta);
    assign w_lim       = $signed({2'b00, i_yaw_limit});

    always_comb begin
        if (w_delta_raw > iefp_pkg::HALF_TURN_S) begin
            w_delta = w_delta_raw - iefp_pkg::FULL_TURN_S;
        end else if (w_delta_raw < -iefp_pkg::HALF_TURN_S) begin
            w_delta = w_delta_raw + iefp_pkg::FULL_TURN_S;
        end else begin
            w_delta = w_delta_raw;
        end
    end

    // Tracker state update
    always_comb begin
        n_base_valid = r_base_valid;
        n_prev_yaw   = r_prev_yaw;
        n_running    = r_running;
        if (o_pop && w_is_zero) begin
            n_base_valid = 1'b0;
            n_running    = '0;
        end else if (w_take_frame) begin
            n_base_valid = 1'b1;
            n_prev_yaw   = i_head.entry.yaw;
            if (!r_base_valid) begin
                n_running = '0;
            end else if (w_sum > w_lim) begin
                n_running = w_lim[16:0];
            end else if (w_sum < -w_lim) begin
                n_running = 17'(-w_lim);
            end else begin
                n_running = w_sum[16:0];
            end
        end
    end

    // Output register: load on a frame, clear when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_take_frame) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_base_valid <= 1'b0;
            r_prev_yaw   <= '0;
            r_running    <= '0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_base_valid <= n_base_valid;
            r_prev_yaw   <= n_prev_yaw;
            r_running    <= n_running;
        end
    end

    // Hold the result fields, running yaw included, until the next frame
    always_ff @(posedge i_clk) begin
        if (w_take_frame) begin
            r_roll    <= i_head.entry.roll;
            r_pitch   <= i_head.entry.pitch;
            r_yaw     <= i_head.entry.yaw;
            r_run_out <= n_running;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_roll    = r_roll;
    assign o_pitch   = r_pitch;
    assign o_yaw     = r_yaw;
    assign o_running = r_run_out;

`ifndef NO_ASSERTIONS
    a_yaw_normalized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_yaw < iefp_pkg::FULL_TURN_U))
        else $error("heading outside one turn");
    a_zero_rebaselines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_is_zero) |=> (!r_base_valid && (r_running == '0)))
        else $error("zero command did not clear tracker");
`endif

endmodule

[rtl/imu_euler_frame_parser.sv]
// Channel   Dir  Payload
// s_axis    in   tuser: op; tdata: data_byte
// m_axis    out  tdata: roll, pitch, yaw, running yaw (65 bits in 72)
// cfg       in   i_cfg_idx 0: device_id, 1: running_yaw_limit
//
// One item is accepted every cycle while the queue is not full; the parser
// classifies it in the cycle of the transfer and hands frame results and zero
// commands through a two-entry queue; frame results then pass the output register.
// Reset is synchronous, active low; there is no clearing pass.
// A stalled m_axis fills the queue, which then holds s_axis_tready low.
module imu_euler_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [15:0] roll, [31:16] pitch, [47:32] yaw,
                                        // [64:48] running yaw, [71:65] zero
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic [7:0]          r_device_id;
    logic [15:0]         r_yaw_limit;
    logic                w_accept;
    logic                w_full;
    logic                w_pop;
    iefp_pkg::t_q_port   w_push;
    iefp_pkg::t_q_port   w_head;
    logic [15:0]         w_roll, w_pitch, w_yaw;
    logic [16:0]         w_running;

    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= iefp_pkg::DEVICE_ID_RST;
            r_yaw_limit <= iefp_pkg::YAW_LIMIT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == iefp_pkg::CFG_DEVICE_ID) begin
                r_device_id <= i_cfg_data[7:0];
            end else begin
                r_yaw_limit <= i_cfg_data;
            end
        end
    end

    iefp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_op        (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .i_device_id (r_device_id),
        .o_push      (w_push)
    );

    iefp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    iefp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_yaw_limit (r_yaw_limit),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_roll      (w_roll),
        .o_pitch     (w_pitch),
        .o_yaw       (w_yaw),
        .o_running   (w_running)
    );

    assign m_axis_tdata = {7'd0, w_running, w_yaw, w_pitch, w_roll};

endmodule

[tb/imu_euler_frame_parser_checker.sv]
module imu_euler_frame_parser_checker
    import iefp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,    // [7:0] data_byte
    input  logic        i_in_user,    // [0] op
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [71:0] i_out_data,   // [15:0] roll, [31:16] pitch, [47:32] yaw,
                                      // [64:48] running yaw, [71:65] zero
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FULL_TURN = 36000;
    localparam int HALF_TURN = 18000;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic [15:0]        yaw;
        logic signed [16:0] running;
    } t_euler;

    // Register copies
    logic [7:0]  dev_id;
    logic [15:0] yaw_limit;

    // Parser and yaw tracker state
    logic        in_frame;
    int          frame_len;
    logic [7:0]  frame_buf [0:MAX_FRAME-1];
    logic        have_baseline;
    int          last_heading;
    int          unwrapped_yaw;

    t_euler      angles_q [$];
    int          mismatches = 0;
    int          checked = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void clear_state();
        dev_id        = DEVICE_ID_RST;
        yaw_limit     = YAW_LIMIT_RST;
        in_frame      = 1'b0;
        frame_len     = 0;
        have_baseline = 1'b0;
        last_heading  = 0;
        unwrapped_yaw = 0;
        angles_q.delete();
    endfunction

    // Advance the parser by one item and queue the angles of a completed frame
    function automatic void track_item(input logic op, input logic [7:0] b);
        int                 n;
        int                 heading;
        int                 delta;
        int                 lim;
        logic signed [15:0] raw;
        t_euler             res;
        if (op == OP_ZERO) begin
            unwrapped_yaw = 0;
            have_baseline = 1'b0;
            return;
        end
        if (!in_frame) begin
            if (b == START_BYTE) begin
                in_frame     = 1'b1;
                frame_buf[0] = b;
                frame_len    = 1;
            end
            return;
        end
        // a full buffer drops the frame and the byte with it
        if (frame_len >= MAX_FRAME) begin
            in_frame  = 1'b0;
            frame_len = 0;
            return;
        end
        frame_buf[frame_len] = b;
        frame_len++;
        if (frame_len == 2 && frame_buf[1] != dev_id) begin
            in_frame  = 1'b0;
            frame_len = 0;
            return;
        end
        if (frame_len < MIN_END_LEN || frame_buf[frame_len-2] != END_FIRST ||
            frame_buf[frame_len-1] != END_SECOND)
            return;
        n         = frame_len;
        in_frame  = 1'b0;
        frame_len = 0;
        if (n < MIN_DATA_LEN)
            return;

        res.roll  = {frame_buf[ANGLE_POS+1], frame_buf[ANGLE_POS]};
        res.pitch = {frame_buf[ANGLE_POS+3], frame_buf[ANGLE_POS+2]};
        raw       = {frame_buf[ANGLE_POS+5], frame_buf[ANGLE_POS+4]};
        heading   = raw;
        if (heading < 0)
            heading += FULL_TURN;

        // first frame after reset or zero only sets the baseline
        if (!have_baseline) begin
            last_heading  = heading;
            have_baseline = 1'b1;
            unwrapped_yaw = 0;
        end else begin
            delta = heading - last_heading;
            if (delta > HALF_TURN)
                delta -= FULL_TURN;
            if (delta < -HALF_TURN)
                delta += FULL_TURN;
            unwrapped_yaw += delta;
            lim = yaw_limit;
            if (unwrapped_yaw > lim)
                unwrapped_yaw = lim;
            if (unwrapped_yaw < -lim)
                unwrapped_yaw = -lim;
            last_heading = heading;
        end
        res.yaw     = heading[15:0];
        res.running = unwrapped_yaw[16:0];
        angles_q.push_back(res);
    endfunction

    // Compare one output transfer with the oldest queued angles
    task automatic check_result(input logic [71:0] data);
        t_euler got;
        t_euler want;
        got.roll    = data[15:0];
        got.pitch   = data[31:16];
        got.yaw     = data[47:32];
        got.running = data[64:48];
        checked++;
        if (angles_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", checked));
        end else begin
            want = angles_q.pop_front();
            if (got.roll !== want.roll)
                report_mismatch($sformatf("result %0d roll: got %0d expected %0d",
                                          checked, got.roll, want.roll));
            if (got.pitch !== want.pitch)
                report_mismatch($sformatf("result %0d pitch: got %0d expected %0d",
                                          checked, got.pitch, want.pitch));
            if (got.yaw !== want.yaw)
                report_mismatch($sformatf("result %0d yaw: got %0d expected %0d",
                                          checked, got.yaw, want.yaw));
            if (got.running !== want.running)
                report_mismatch($sformatf("result %0d running yaw: got %0d expected %0d",
                                          checked, got.running, want.running));
            if (data[71:65] !== 7'd0)
                report_mismatch($sformatf("result %0d padding: got %b expected zero",
                                          checked, data[71:65]));
        end
    endtask

    // Watch register writes and both channels at every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DEVICE_ID)
                    dev_id = i_cfg_data[7:0];
                else
                    yaw_limit = i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                track_item(i_in_user, i_in_data);
            if (i_out_valid && i_out_ready)
                check_result(i_out_data);
        end
        o_errors  <= mismatches;
        o_pending <= angles_q.size();
        o_results <= checked;
    end

endmodule

[tb/imu_euler_frame_parser_tb.sv]
module imu_euler_frame_parser_tb;
    import iefp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FULL_TURN   = 36000;
    localparam int HALF_TURN   = 18000;
    localparam int SEG_ITEMS   = 80;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_PAUSE = 8;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;     // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;            // [15:0] roll, [31:16] pitch, [47:32] yaw,
                                          // [64:48] running yaw, [71:65] zero
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [15:0] i_cfg_data = 16'h0000;

    int          chk_errors;
    int          chk_pending;
    int          chk_results;

    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          hold_asked = 0;
    int          hold_served = 0;
    int          cycle_count = 0;
    int          items_sent = 0;
    int          ignored_items = 0;
    int          frames_sent = 0;
    logic [7:0]  cur_dev_id = DEVICE_ID_RST;
    int          gen_heading = 0;
    int          drift_dir = 1;

    imu_euler_frame_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    imu_euler_frame_parser_checker frame_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending),
        .o_results   (chk_results)
    );

    always #6 i_clk = ~i_clk;

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due", cycle_count, chk_pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Output side: random stalls, plus a long hold-off when one is requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_served) begin
                hold_served++;
                for (int c = 0; c < HOLD_CYCLES; c++) begin
                    m_axis_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Offer one item and hold it until the transfer
    task automatic send_item(input logic op, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Stop offering until every frame result is out, then let the queue settle
    task automatic wait_drain(input int pause);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (pause) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [7:0] id, input logic [15:0] lim);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DEVICE_ID;
        i_cfg_data <= {8'($urandom), id};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_YAW_LIMIT;
        i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_dev_id = id;
    endtask

    // Build a frame of len bytes around the given angles; a zero command
    // goes in before byte zero_at when that is not negative
    task automatic send_frame(input int len, input logic [7:0] id, input logic [15:0] roll,
                              input logic [15:0] pitch, input logic [15:0] yaw,
                              input int zero_at);
        logic [7:0] frame [0:MAX_FRAME-1];
        for (int i = 0; i < MAX_FRAME; i++)
            frame[i] = 8'($urandom);
        frame[0]           = START_BYTE;
        frame[1]           = id;
        frame[ANGLE_POS]   = roll[7:0];
        frame[ANGLE_POS+1] = roll[15:8];
        frame[ANGLE_POS+2] = pitch[7:0];
        frame[ANGLE_POS+3] = pitch[15:8];
        frame[ANGLE_POS+4] = yaw[7:0];
        frame[ANGLE_POS+5] = yaw[15:8];
        frame[len-2]       = END_FIRST;
        frame[len-1]       = END_SECOND;
        // break any terminator that would end the frame early
        for (int i = MIN_END_LEN - 1; i < len - 1; i++)
            if (frame[i-1] == END_FIRST && frame[i] == END_SECOND)
                frame[i] = 8'h0B;
        for (int i = 0; i < len; i++) begin
            if (i == zero_at)
                send_item(OP_ZERO, 8'($urandom));
            send_item(OP_BYTE, frame[i]);
        end
        frames_sent++;
    endtask

    // Fill the frame buffer with no terminator, then one byte past its end
    task automatic send_overflow(input logic [7:0] last_byte);
        logic [7:0] b;
        send_item(OP_BYTE, START_BYTE);
        send_item(OP_BYTE, cur_dev_id);
        repeat (MAX_FRAME - 2) begin
            b = 8'($urandom);
            if (b == END_FIRST)
                b = 8'h0E;
            send_item(OP_BYTE, b);
        end
        send_item(OP_BYTE, last_byte);
    endtask

    // Heading that mostly drifts one way so the running yaw saturates
    function automatic logic [15:0] next_heading();
        int pick;
        int step;
        pick = $urandom_range(99);
        if (pick < 10)
            return 16'($urandom);
        if ($urandom_range(9) == 0)
            drift_dir = -drift_dir;
        if (pick < 20)
            step = HALF_TURN;
        else
            step = $urandom_range(HALF_TURN - 1);
        gen_heading = (gen_heading + drift_dir * step + FULL_TURN) % FULL_TURN;
        if (gen_heading >= HALF_TURN && $urandom_range(1) == 1)
            return 16'(gen_heading - FULL_TURN);
        return 16'(gen_heading);
    endfunction

    task automatic send_random_frame();
        int len;
        int zero_at;
        if ($urandom_range(9) == 0)
            len = $urandom_range(MAX_FRAME, MIN_DATA_LEN);
        else
            len = $urandom_range(26, MIN_DATA_LEN);
        zero_at = ($urandom_range(11) == 0) ? int'($urandom_range(len - 1)) : -1;
        send_frame(len, cur_dev_id, 16'($urandom), 16'($urandom), next_heading(), zero_at);
    endtask

    // Mostly good frames, the rest commands, short, foreign, overlong and noise
    task automatic random_item();
        int         pick;
        int         n;
        logic [7:0] bad_id;
        pick = $urandom_range(99);
        if (pick < 70) begin
            send_random_frame();
        end else if (pick < 78) begin
            send_item(OP_ZERO, 8'($urandom));
        end else if (pick < 85) begin
            send_frame($urandom_range(MIN_DATA_LEN - 1, MIN_END_LEN), cur_dev_id,
                       16'($urandom), 16'($urandom), 16'($urandom), -1);
        end else if (pick < 90) begin
            bad_id = cur_dev_id ^ 8'($urandom_range(255, 1));
            send_item(OP_BYTE, START_BYTE);
            send_item(OP_BYTE, bad_id);
            n = $urandom_range(4);
            repeat (n) send_item(OP_BYTE, 8'($urandom));
            ignored_items += n;
        end else if (pick < 94) begin
            send_overflow(($urandom_range(1) == 1) ? START_BYTE : 8'($urandom));
        end else begin
            n = $urandom_range(6, 1);
            repeat (n) send_item(OP_BYTE, 8'($urandom));
            ignored_items += n;
        end
    endtask

    initial begin
        int seg_start;
        int h;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: hunting, angle extremes, wrap, short, foreign, overflow
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, END_FIRST);
        send_item(OP_BYTE, END_SECOND);
        send_frame(MIN_DATA_LEN, cur_dev_id, 16'h7FFF, 16'h8000, 16'h0000, -1);
        send_frame(25, cur_dev_id, 16'h8000, 16'h7FFF, 16'hFFFF, -1);
        send_frame(25, cur_dev_id, 16'h0000, 16'hFFFF, 16'd0, -1);
        send_frame(25, cur_dev_id, 16'h1234, 16'h0000, 16'd18000, -1);
        send_frame(25, cur_dev_id, 16'hFFFF, 16'h5555, 16'd0, -1);
        send_frame(25, cur_dev_id, 16'hAAAA, 16'h8001, 16'h7FFF, -1);
        send_frame(25, cur_dev_id, 16'h0001, 16'h7FFE, 16'h8000, -1);
        send_frame(MIN_DATA_LEN - 1, cur_dev_id, 16'h1111, 16'h2222, 16'h3333, -1);
        send_frame(MIN_END_LEN, cur_dev_id, 16'h0000, 16'h0000, 16'h0000, -1);
        send_frame(25, cur_dev_id ^ 8'h80, 16'h0000, 16'h0000, 16'd100, -1);
        send_overflow(START_BYTE);
        send_frame(MAX_FRAME, cur_dev_id, 16'h4321, 16'hBCDE, 16'd20000, -1);
        send_item(OP_ZERO, 8'hA5);
        send_frame(25, cur_dev_id, 16'h0102, 16'h0304, 16'd9000, 12);
        // drive the running yaw into the positive and then the negative bound
        h = 9000;
        repeat (5) begin
            h = (h + 17000) % FULL_TURN;
            send_frame(25, cur_dev_id, 16'($urandom), 16'($urandom), 16'(h), -1);
        end
        repeat (7) begin
            h = (h + FULL_TURN - 17000) % FULL_TURN;
            send_frame(25, cur_dev_id, 16'($urandom), 16'($urandom), 16'(h - FULL_TURN), -1);
        end

        // Random phases, each with its own register set and one of four idle mixes
        for (int seg = 0; seg < 8; seg++) begin
            wait_drain(DRAIN_PAUSE);
            case (seg)
                0: write_cfg(DEVICE_ID_RST, YAW_LIMIT_RST);
                1: write_cfg(8'h00, 16'd0);
                2: write_cfg(8'hFF, 16'hFFFF);
                3: write_cfg(START_BYTE, 16'd500);
                4: write_cfg(8'($urandom), 16'($urandom));
                5: write_cfg(END_FIRST, 16'd18000);
                6: write_cfg(8'($urandom), 16'd1);
                default: write_cfg(8'($urandom), 16'($urandom_range(36000)));
            endcase
            src_idle_pct   = (seg % 4 == 1) ? 84 : (seg % 4 == 3) ? 34 : 0;
            sink_stall_pct = (seg % 4 == 2) ? 84 : (seg % 4 == 3) ? 34 : 0;
            // hold the output off while frames and commands keep coming
            if (seg == 0) begin
                hold_asked <= hold_asked + 1;
                repeat (3) send_frame(MIN_DATA_LEN, cur_dev_id, 16'($urandom),
                                      16'($urandom), next_heading(), -1);
                repeat (4) send_item(OP_ZERO, 8'($urandom));
                repeat (2) send_random_frame();
            end
            seg_start = items_sent - ignored_items;
            while (items_sent - ignored_items - seg_start < SEG_ITEMS)
                random_item();
        end

        wait_drain(4 * DRAIN_PAUSE);
        $display("Run covered %0d input transfers, %0d frames offered, %0d results checked",
                 items_sent, frames_sent, chk_results);
        $display("over 8 register settings, four idle mixes and a long output hold-off");
        if (chk_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
